@@ hdl/stt_pkg.sv @@
// Shared types and constants for the software timer table.
package stt_pkg;
    localparam int Slots = 64;
    localparam int SlotW = 6;
    localparam int HwW = 7;
    localparam int WaitStart = 1000;
    localparam int WaitFloor = 10;

    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_DEL = 2'd1;
    localparam logic [1:0] MODE_TICK = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    localparam logic [1:0] KIND_ADD = 2'd0;
    localparam logic [1:0] KIND_DEL = 2'd1;
    localparam logic [1:0] KIND_FIRE = 2'd2;
    localparam logic [1:0] KIND_WAIT = 2'd3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_BAD = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    typedef struct packed {
        logic [1:0] mode;
        logic [31:0] now_time;
        logic [5:0] slot;
        logic [15:0] handler;
        logic [31:0] tag_id;
        logic [31:0] tag_data;
        logic repeat_req;
        logic [30:0] period;
    } t_in;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] out_slot;
        logic [15:0] out_handler;
        logic [31:0] out_id;
        logic [31:0] out_data;
        logic [1:0] status;
        logic [9:0] next_wait;
        logic last;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE, S_ADD_SCAN, S_ADD_WR, S_DEL_RD, S_DEL_CHK,
        S_TICK_RD, S_TICK_CHK, S_EMIT, S_WAIT_EMIT
    } t_state;

    typedef struct packed {
        logic load_in;
        logic clr_idx;
        logic inc_idx;
        logic rd_entry;
        logic wr_add;
        logic do_del;
        logic do_fire_upd;
        logic acc_wait;
        logic init_wait;
        logic send;
        logic [1:0] send_kind;
        logic [1:0] send_status;
        logic send_last;
    } t_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic idx_free;
        logic idx_at_hw;
        logic idx_end;
        logic full;
        logic del_bad;
        logic del_match;
        logic fire;
        logic out_busy;
    } t_stat;
endpackage

@@ hdl/stt_if.sv @@
// Valid-ready channel interface carrying one beat of payload.
interface stt_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hdl/stt_ctrl.sv @@
// Controller state machine for the software timer table.
module stt_ctrl (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  stt_pkg::t_stat i_stat,
    output stt_pkg::t_cmd o_cmd
);
    import stt_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    o_cmd.clr_idx = 1'b1;
                    o_cmd.init_wait = 1'b1;
                    n_state = S_ADD_SCAN;
                end
            end
            S_ADD_SCAN: begin
                unique case (i_stat.mode)
                    MODE_ADD: begin
                        if (i_stat.idx_free || i_stat.idx_at_hw) begin
                            n_state = S_ADD_WR;
                        end else begin
                            o_cmd.inc_idx = 1'b1;
                        end
                    end
                    MODE_DEL: n_state = S_DEL_RD;
                    MODE_TICK: n_state = S_TICK_RD;
                    default: n_state = S_IDLE;
                endcase
            end
            S_ADD_WR: begin
                if (!i_stat.out_busy) begin
                    o_cmd.send = 1'b1;
                    o_cmd.send_kind = KIND_ADD;
                    o_cmd.send_last = 1'b1;
                    if (i_stat.full) begin
                        o_cmd.send_status = ST_FULL;
                    end else begin
                        o_cmd.send_status = ST_OK;
                        o_cmd.wr_add = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            S_DEL_RD: begin
                o_cmd.rd_entry = 1'b1;
                n_state = S_DEL_CHK;
            end
            S_DEL_CHK: begin
                if (!i_stat.out_busy) begin
                    o_cmd.send = 1'b1;
                    o_cmd.send_kind = KIND_DEL;
                    o_cmd.send_last = 1'b1;
                    if (i_stat.del_bad) begin
                        o_cmd.send_status = ST_BAD;
                    end else if (!i_stat.del_match) begin
                        o_cmd.send_status = ST_MISMATCH;
                    end else begin
                        o_cmd.send_status = ST_OK;
                        o_cmd.do_del = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            S_TICK_RD: begin
                if (i_stat.idx_end) begin
                    n_state = S_WAIT_EMIT;
                end else begin
                    o_cmd.rd_entry = 1'b1;
                    n_state = S_TICK_CHK;
                end
            end
            S_TICK_CHK: begin
                if (i_stat.idx_free) begin
                    o_cmd.inc_idx = 1'b1;
                    n_state = S_TICK_RD;
                end else begin
                    o_cmd.acc_wait = 1'b1;
                    if (i_stat.fire) begin
                        n_state = S_EMIT;
                    end else begin
                        o_cmd.inc_idx = 1'b1;
                        n_state = S_TICK_RD;
                    end
                end
            end
            S_EMIT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.send = 1'b1;
                    o_cmd.send_kind = KIND_FIRE;
                    o_cmd.send_status = ST_OK;
                    o_cmd.do_fire_upd = 1'b1;
                    o_cmd.inc_idx = 1'b1;
                    n_state = S_TICK_RD;
                end
            end
            S_WAIT_EMIT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.send = 1'b1;
                    o_cmd.send_kind = KIND_WAIT;
                    o_cmd.send_status = ST_OK;
                    o_cmd.send_last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

@@ hdl/stt_dp.sv @@
// Datapath of the software timer table: entry memories, scan index and result register.
module stt_dp (
    input  logic i_clk,
    input  logic i_rst_n,
    input  stt_pkg::t_in i_in,
    input  stt_pkg::t_cmd i_cmd,
    output stt_pkg::t_stat o_stat,
    output logic o_out_valid,
    input  logic i_out_ready,
    output stt_pkg::t_out o_out
);
    import stt_pkg::*;

    logic [Slots-1:0] r_used;
    logic [31:0] m_deadline [Slots];
    logic [15:0] m_handler [Slots];
    logic [31:0] m_id [Slots];
    logic [31:0] m_data [Slots];
    logic m_repeat [Slots];
    logic [30:0] m_period [Slots];

    t_in r_in;
    logic [HwW-1:0] r_hw;
    logic [HwW-1:0] r_idx;
    logic signed [31:0] r_wait;
    logic [31:0] r_rd_deadline;
    logic [15:0] r_rd_handler;
    logic [31:0] r_rd_id;
    logic [31:0] r_rd_data;
    logic r_rd_repeat;
    logic [30:0] r_rd_period;
    logic r_out_valid;
    t_out r_out;
    t_out n_out;

    logic [SlotW-1:0] idx_a;
    logic [SlotW-1:0] rd_a;
    logic signed [31:0] diff;
    logic [9:0] wait_clamped;

    assign idx_a = r_idx[SlotW-1:0];
    assign rd_a = (r_in.mode == MODE_DEL) ? r_in.slot : idx_a;
    assign diff = $signed(r_rd_deadline - r_in.now_time);
    assign wait_clamped = (r_wait < 32'sd10) ? 10'(WaitFloor) : r_wait[9:0];

    assign o_stat.mode = r_in.mode;
    assign o_stat.idx_free = !r_used[idx_a];
    assign o_stat.idx_at_hw = (r_idx == r_hw);
    assign o_stat.idx_end = (r_idx >= r_hw) || (r_idx >= HwW'(Slots));
    assign o_stat.full = (r_idx >= HwW'(Slots));
    assign o_stat.del_bad = (r_in.slot == '0) || ({1'b0, r_in.slot} >= r_hw)
                            || !r_used[r_in.slot];
    assign o_stat.del_match = (r_rd_handler == r_in.handler);
    assign o_stat.fire = (diff <= 32'sd0);
    assign o_stat.out_busy = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out = r_out;

    always_comb begin
        n_out = '0;
        n_out.kind = i_cmd.send_kind;
        n_out.status = i_cmd.send_status;
        n_out.last = i_cmd.send_last;
        case (i_cmd.send_kind)
            KIND_ADD: n_out.out_slot = (i_cmd.send_status == ST_FULL) ? '0 : idx_a;
            KIND_DEL: n_out.out_slot = r_in.slot;
            KIND_FIRE: begin
                n_out.out_slot = idx_a;
                n_out.out_handler = r_rd_handler;
                n_out.out_id = r_rd_id;
                n_out.out_data = r_rd_data;
            end
            default: n_out.next_wait = wait_clamped;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_hw <= HwW'(1);
            r_idx <= HwW'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_idx) begin
                r_idx <= HwW'(1);
            end else if (i_cmd.inc_idx) begin
                r_idx <= r_idx + HwW'(1);
            end
            if (i_cmd.wr_add) begin
                r_used[idx_a] <= 1'b1;
                if (r_idx >= r_hw) begin
                    r_hw <= r_idx + HwW'(1);
                end
            end
            if (i_cmd.do_del) begin
                r_used[r_in.slot] <= 1'b0;
            end
            if (i_cmd.do_fire_upd && !r_rd_repeat) begin
                r_used[idx_a] <= 1'b0;
            end
            if (i_cmd.send) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in;
        end
        if (i_cmd.init_wait) begin
            r_wait <= 32'(WaitStart);
        end else if (i_cmd.acc_wait && diff < r_wait) begin
            r_wait <= diff;
        end
        if (i_cmd.rd_entry) begin
            r_rd_deadline <= m_deadline[rd_a];
            r_rd_handler <= m_handler[rd_a];
            r_rd_id <= m_id[rd_a];
            r_rd_data <= m_data[rd_a];
            r_rd_repeat <= m_repeat[rd_a];
            r_rd_period <= m_period[rd_a];
        end
        if (i_cmd.wr_add) begin
            m_deadline[idx_a] <= r_in.now_time;
            m_handler[idx_a] <= r_in.handler;
            m_id[idx_a] <= r_in.tag_id;
            m_data[idx_a] <= r_in.tag_data;
            m_repeat[idx_a] <= r_in.repeat_req;
            m_period[idx_a] <= r_in.period;
        end else if (i_cmd.do_fire_upd && r_rd_repeat) begin
            m_deadline[idx_a] <= r_rd_deadline + {1'b0, r_rd_period};
        end
        if (i_cmd.send) begin
            r_out <= n_out;
        end
    end
endmodule

@@ hdl/software_timer_table.sv @@
// Top level of the software timer table.
// The block holds 63 usable timers (slot 0 is never used). Requests arrive as
// beats on the input channel: add, delete or tick. Results leave as beats on
// the output channel, and the final beat of each request carries last.
// An add scans up from slot 1 for a free slot, one slot a cycle. A tick
// visits each slot below the high-water mark, emits a fire beat for each
// firing timer and then emits the next-wait beat. Mode 3 is dropped with
// no result. One request is handled at a time; the input is ready only
// while the controller is idle. Reset clears all in-use flags and sets the
// high-water mark to one, and entry contents stay undefined until written.
// When the receiver stalls, the result register holds its beat and the
// controller waits with the next beat until it is taken.
module software_timer_table (
    input  logic i_clk,
    input  logic i_rst_n,
    stt_if.sink i_req,
    stt_if.source o_rsp
);
    import stt_pkg::*;

    t_cmd cmd;
    t_stat stat;

    stt_ctrl u_ctrl (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_req.valid),
        .o_in_ready(i_req.ready),
        .i_stat(stat),
        .o_cmd(cmd)
    );

    stt_dp u_dp (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(i_req.data),
        .i_cmd(cmd),
        .o_stat(stat),
        .o_out_valid(o_rsp.valid),
        .i_out_ready(o_rsp.ready),
        .o_out(o_rsp.data)
    );
endmodule
